// ----- hdl/obbfc_pkg.sv -----
// Shared constants for the oriented box frustum cull block.
`default_nettype none
package obbfc_pkg;
	localparam int NORM_BITS  = 14;
	localparam int OFFS_BITS  = 22;
	localparam int NUM_PLANES = 6;
	localparam int FIELD_BITS = 60;
	localparam int CFG_BITS   = 64;
	localparam int IDX_BITS   = 3;
	localparam int ACC_BITS   = 64;
endpackage
`default_nettype wire

// ----- hdl/obbfc_plane.sv -----
// One plane test: distance plus radius sign from centre and scaled axes.
`default_nettype none
module obbfc_plane #(
	parameter int VB = 44
) (
	input  wire                                   clk,
	input  wire                                   en,
	input  wire [obbfc_pkg::CFG_BITS-1:0]         plane,
	input  wire signed [VB-1:0]                   ctr [3],
	input  wire signed [VB-1:0]                   ax  [3][3],
	output logic                                  pass
);
	logic signed [obbfc_pkg::NORM_BITS-1:0] n [3];
	logic signed [obbfc_pkg::OFFS_BITS-1:0] off;
	logic signed [obbfc_pkg::ACC_BITS-1:0]  pc_s1 [3];
	logic signed [obbfc_pkg::ACC_BITS-1:0]  pa_s1 [3][3];
	logic signed [obbfc_pkg::ACC_BITS-1:0]  off_s1;
	logic signed [obbfc_pkg::ACC_BITS-1:0]  d_s2, r_s2;
	logic signed [obbfc_pkg::ACC_BITS-1:0]  dot [3];

	always_comb begin
		for (int i = 0; i < 3; i++)
			n[i] = plane[i*obbfc_pkg::NORM_BITS +: obbfc_pkg::NORM_BITS];
		off = plane[3*obbfc_pkg::NORM_BITS +: obbfc_pkg::OFFS_BITS];
		for (int j = 0; j < 3; j++)
			dot[j] = pa_s1[j][0] + pa_s1[j][1] + pa_s1[j][2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pc_s1[i] <= obbfc_pkg::ACC_BITS'(n[i] * ctr[i]);
				for (int j = 0; j < 3; j++)
					pa_s1[j][i] <= obbfc_pkg::ACC_BITS'(n[i] * ax[j][i]);
			end
			off_s1 <= obbfc_pkg::ACC_BITS'(off) <<< 23;
			d_s2 <= pc_s1[0] + pc_s1[1] + pc_s1[2] - off_s1;
			r_s2 <= (dot[0] < 0 ? -dot[0] : dot[0]) + (dot[1] < 0 ? -dot[1] : dot[1])
				+ (dot[2] < 0 ? -dot[2] : dot[2]);
			pass <= (d_s2 + r_s2) >= 0;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/oriented_box_frustum_cull.sv -----
// Top level of the oriented box frustum cull block.
// One box per beat on s_axis (tdata: axis_x_column, axis_y_column,
// axis_z_column, translation, box_min, box_max at 60 bits each from bit 0).
// One result beat per box on m_axis (tdata bit 0: visible).
// Planes are written through cfg_we/cfg_index/cfg_data; the user must do so only
// while idle, as the block does not enforce it. Index 0..5 selects near, far, left,
// right, top, bottom; other indexes are dropped. One box per cycle while the output
// is not stalled, through five register stages (sum/extent, centre/axis multiply,
// plane multiply, distance/radius, compare); the plane AND drives tdata directly.
// Reset clears all planes (every box visible) and the valid bits.
// When m_axis_tvalid is high and m_axis_tready is low, the whole pipeline holds;
// s_axis_tready is high whenever the output stage is empty or being drained.
`default_nettype none
module oriented_box_frustum_cull #(
	parameter int COORD_BITS = 20
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [359:0] s_axis_tdata,   // axis_x_column, axis_y_column, axis_z_column,
	                                    // translation, box_min, box_max
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // visible
	input  wire         cfg_we,
	input  wire [obbfc_pkg::IDX_BITS-1:0] cfg_index,
	input  wire [obbfc_pkg::CFG_BITS-1:0] cfg_data
);
	localparam int CB = COORD_BITS;
	localparam int VB = 2*CB + 4;
	localparam int FB = obbfc_pkg::FIELD_BITS;
	localparam int NSTG = 5;

	logic [obbfc_pkg::CFG_BITS-1:0] plane_q [obbfc_pkg::NUM_PLANES];
	logic [NSTG-1:0] vld_q;
	logic en;
	logic signed [CB-1:0] comp [6][3];
	logic signed [CB:0] sum_s1 [3], ext_s1 [3];
	logic signed [CB-1:0] col_s1 [3][3], t_s1 [3];
	logic signed [VB-1:0] ctr_s2 [3], ax_s2 [3][3];
	logic [obbfc_pkg::NUM_PLANES-1:0] pass;
	logic [FB*6-1:0] din;

	assign en = !m_axis_tvalid || m_axis_tready || !vld_q[NSTG-1];
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[NSTG-1];
	assign m_axis_tdata = {7'd0, &pass};
	assign din = s_axis_tdata;

	always_comb begin
		logic [FB+CB*3-1:0] f;
		for (int k = 0; k < 6; k++) begin
			f = (FB+CB*3)'(din[k*FB +: FB]);
			for (int i = 0; i < 3; i++)
				comp[k][i] = f[i*CB +: CB];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			for (int p = 0; p < obbfc_pkg::NUM_PLANES; p++)
				plane_q[p] <= '0;
		end else begin
			if (cfg_we && cfg_index < obbfc_pkg::IDX_BITS'(obbfc_pkg::NUM_PLANES))
				plane_q[cfg_index] <= cfg_data;
			if (en)
				vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sum_s1[i] <= (CB+1)'(comp[4][i]) + (CB+1)'(comp[5][i]);
				ext_s1[i] <= (CB+1)'(comp[5][i]) - (CB+1)'(comp[4][i]);
				t_s1[i] <= comp[3][i];
				for (int j = 0; j < 3; j++)
					col_s1[j][i] <= comp[j][i];
			end
			for (int i = 0; i < 3; i++) begin
				ctr_s2[i] <= (VB'(t_s1[i]) <<< 11) + VB'(col_s1[0][i] * sum_s1[0])
					+ VB'(col_s1[1][i] * sum_s1[1]) + VB'(col_s1[2][i] * sum_s1[2]);
				for (int j = 0; j < 3; j++)
					ax_s2[j][i] <= VB'(col_s1[j][i] * ext_s1[j]);
			end
		end
	end

	for (genvar p = 0; p < obbfc_pkg::NUM_PLANES; p++) begin : g_pl
		obbfc_plane #(.VB(VB)) u_pl (
			.clk(clk), .en(en), .plane(plane_q[p]),
			.ctr(ctr_s2), .ax(ax_s2), .pass(pass[p])
		);
	end
endmodule
`default_nettype wire

// ----- hdl/obbfc_check.sv -----
// Port-level checker for the oriented box frustum cull block.
`default_nettype none
module obbfc_check (
	input wire clk,
	input wire arst_n,
	input wire s_axis_tvalid,
	input wire s_axis_tready,
	input wire m_axis_tvalid,
	input wire m_axis_tready,
	input wire [7:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0) else $error("pad bits set");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready) else $error("input blocked while output empty");
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> !m_axis_tvalid)
		else $error("valid out of reset");
endmodule
bind oriented_box_frustum_cull obbfc_check u_chk (.*);
`default_nettype wire
